// ----- rtl/core/fpm_pkg.sv -----
// Shared types and constants of the frame pacing monitor.
package fpm_pkg;

  // Event codes carried on the input tuser
  typedef enum logic [2:0] {
    CMD_RECEIVED = 3'd0,
    CMD_RENDERED = 3'd1,
    CMD_SWAPPED  = 3'd2,
    CMD_CANCEL   = 3'd3,
    CMD_CLEAR    = 3'd4
  } fpm_cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACC,
    ST_MUL,
    ST_DIV_AVG,
    ST_DIV_FPS,
    ST_DONE
  } fpm_state_t;

  // Event counter slots
  localparam int          CNT_NUM       = 5;
  localparam logic [2:0]  CNT_RECEIVED  = 3'd0;
  localparam logic [2:0]  CNT_COALESCED = 3'd1;
  localparam logic [2:0]  CNT_RENDERED  = 3'd2;
  localparam logic [2:0]  CNT_DUPLICATE = 3'd3;
  localparam logic [2:0]  CNT_SWAPPED   = 3'd4;

  // Field widths
  localparam int GEN_W     = 48;
  localparam int OUT_CNT_W = 32;
  localparam int SUM_W     = 64;
  localparam int IVC_W     = 32;
  localparam int FPS_W     = 28;
  localparam int PROD_W    = IVC_W + FPS_W;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 288;

  // Frames per second scale: one million microseconds in Q.8
  localparam logic [FPS_W-1:0] FPS_SCALE = 28'd256000000;

  // Divider step counts and counter width
  localparam int AVG_STEPS = 64;
  localparam int FPS_STEPS = FPS_W;
  localparam int ITER_W    = 7;

endpackage

// ----- rtl/core/frame_pacing_monitor.sv -----
// Top level of the frame pacing monitor: event decode, statistics and shared divider.
//
// Each input transaction carries one frame event (received, rendered, swapped, cancel
// pending or clear) and produces exactly one output transaction holding a snapshot
// of all statistics after that event. The event is captured, then applied; non-swap
// events and repeated or zero-generation swaps then go to the snapshot. A new swap
// measures its interval when applied, then accumulates it and goes to the snapshot
// if no interval has been accumulated yet. A new swap once intervals exist
// recomputes the average interval and frames per second: a 32x28 multiply forms the
// frames-per-second dividend, then one shared restoring divider, producing one
// quotient bit per cycle, runs 64 steps for the average and 28 steps for the rate.
// The snapshot is loaded once the output register is free. The input is not ready
// while an event is in progress; a finished snapshot sits in an output register so
// the next event can be accepted while it waits.
module frame_pacing_monitor
  import fpm_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int TIME_WIDTH  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [47:0] generation, [95:48] timestamp_us
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] command
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] received_frames, [63:32] coalesced_frames, [95:64] rendered_frames,
  // [127:96] duplicate_renders, [159:128] swapped_frames, [160] pending_now,
  // [161] max_pending, [209:162] max_swap_interval_us,
  // [257:210] avg_swap_interval_us, [285:258] fps_q8, [287:286] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int TW     = (TIME_WIDTH < GEN_W) ? TIME_WIDTH : GEN_W;
  localparam int CW_EXT = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  fpm_state_t state_r, state_nxt;

  // Latched event
  logic [2:0]       cmd_r,  cmd_nxt;
  logic [GEN_W-1:0] gen_r,  gen_nxt;
  logic [TW-1:0]    time_r, time_nxt;

  // Statistics state
  logic [GEN_W-1:0]       latest_r,  latest_nxt;
  logic [GEN_W-1:0]       pgen_r,    pgen_nxt;
  logic [GEN_W-1:0]       rgen_r,    rgen_nxt;
  logic [GEN_W-1:0]       sgen_r,    sgen_nxt;
  logic [TW-1:0]          stime_r,   stime_nxt;
  logic [SUM_W-1:0]       sum_r,     sum_nxt;
  logic [IVC_W-1:0]       ivc_r,     ivc_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r [CNT_NUM];
  logic [COUNT_WIDTH-1:0] cnt_nxt [CNT_NUM];
  logic                   pnow_r,    pnow_nxt;
  logic                   pmax_r,    pmax_nxt;
  logic [TW-1:0]          maxiv_r,   maxiv_nxt;
  logic [GEN_W-1:0]       avg_r,     avg_nxt;
  logic [FPS_W-1:0]       fps_r,     fps_nxt;

  // Swap interval working registers
  logic [TW-1:0]     iv_r,    iv_nxt;
  logic              ivok_r,  ivok_nxt;
  logic [PROD_W-1:0] prod_r,  prod_nxt;

  // Shared divider registers
  logic [SUM_W-1:0]  rem_r,  rem_nxt;
  logic [SUM_W-1:0]  quo_r,  quo_nxt;
  logic [SUM_W-1:0]  dsr_r,  dsr_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  // Output register
  logic                  oval_r,  oval_nxt;
  logic [OUT_DATA_W-1:0] odata_r, odata_nxt;

  // Control decode
  logic swap_new;
  logic no_ratio;
  logic div_last;
  logic out_load;

  // Datapath helpers
  logic [SUM_W:0]     trial;
  logic               trial_ge;
  logic [SUM_W:0]     trial_diff;
  logic [SUM_W-1:0]   rem_step;
  logic [SUM_W-1:0]   quo_step;
  logic [SUM_W:0]     sum_ext;
  logic [CW_EXT-1:0]  cnt_ext [CNT_NUM];

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Decode of the current event and sequencer conditions
  assign swap_new = (gen_r != '0) && (gen_r != sgen_r);
  assign no_ratio = (ivc_r == '0) || (sum_r == '0);
  assign div_last = (state_r == ST_DIV_AVG) ? (iter_r == ITER_W'(AVG_STEPS - 1))
                                            : (iter_r == ITER_W'(FPS_STEPS - 1));

  // Restoring divider step: one quotient bit per cycle
  assign trial      = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge   = (trial >= {1'b0, dsr_r});
  assign trial_diff = trial - {1'b0, dsr_r};
  assign rem_step   = trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
  assign quo_step   = {quo_r[SUM_W-2:0], trial_ge};

  // Interval accumulation with carry for the overflow guard
  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(iv_r);

  // Counters widened before taking the low 32 bits
  always_comb begin
    for (int i = 0; i < CNT_NUM; i++) begin
      cnt_ext[i] = CW_EXT'(cnt_r[i]);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_r == CMD_SWAPPED && swap_new) state_nxt = ST_ACC;
        else state_nxt = ST_DONE;
      end
      ST_ACC: state_nxt = ST_MUL;
      ST_MUL: begin
        if (no_ratio) state_nxt = ST_DONE;
        else state_nxt = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_last) state_nxt = ST_DIV_FPS;
      end
      ST_DIV_FPS: begin
        if (div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!oval_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_DONE: out_load  = !oval_r || out_tready;
      default: begin
        in_tready = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

  // Statistics and divider datapath
  always_comb begin
    cmd_nxt   = cmd_r;
    gen_nxt   = gen_r;
    time_nxt  = time_r;
    latest_nxt = latest_r;
    pgen_nxt  = pgen_r;
    rgen_nxt  = rgen_r;
    sgen_nxt  = sgen_r;
    stime_nxt = stime_r;
    sum_nxt   = sum_r;
    ivc_nxt   = ivc_r;
    for (int i = 0; i < CNT_NUM; i++) cnt_nxt[i] = cnt_r[i];
    pnow_nxt  = pnow_r;
    pmax_nxt  = pmax_r;
    maxiv_nxt = maxiv_r;
    avg_nxt   = avg_r;
    fps_nxt   = fps_r;
    iv_nxt    = iv_r;
    ivok_nxt  = ivok_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dsr_nxt   = dsr_r;
    iter_nxt  = iter_r;
    odata_nxt = odata_r;
    oval_nxt  = out_tready ? 1'b0 : oval_r;

    case (state_r)
      // Capture the event
      ST_IDLE: begin
        cmd_nxt  = in_tuser;
        gen_nxt  = in_tdata[GEN_W-1:0];
        time_nxt = in_tdata[GEN_W +: TW];
      end

      // Apply the event to the generation and pending state
      ST_EXEC: begin
        ivok_nxt = 1'b0;
        case (cmd_r)
          CMD_RECEIVED: begin
            if (gen_r != '0 && gen_r != latest_r) begin
              if (pgen_r != '0) cnt_nxt[CNT_COALESCED] = sat_inc(cnt_r[CNT_COALESCED]);
              latest_nxt = gen_r;
              pgen_nxt   = gen_r;
              cnt_nxt[CNT_RECEIVED] = sat_inc(cnt_r[CNT_RECEIVED]);
              pnow_nxt   = 1'b1;
              pmax_nxt   = 1'b1;
            end
          end
          CMD_RENDERED: begin
            if (gen_r != '0) begin
              if (gen_r == rgen_r) begin
                cnt_nxt[CNT_DUPLICATE] = sat_inc(cnt_r[CNT_DUPLICATE]);
              end else begin
                rgen_nxt = gen_r;
                cnt_nxt[CNT_RENDERED] = sat_inc(cnt_r[CNT_RENDERED]);
                if (pgen_r != '0 && gen_r >= pgen_r) begin
                  pgen_nxt = '0;
                  pnow_nxt = 1'b0;
                end
              end
            end
          end
          CMD_SWAPPED: begin
            if (swap_new) begin
              sgen_nxt = gen_r;
              cnt_nxt[CNT_SWAPPED] = sat_inc(cnt_r[CNT_SWAPPED]);
              // Interval only when a previous time exists and time moved on
              if (stime_r != '0 && time_r > stime_r) begin
                iv_nxt   = time_r - stime_r;
                ivok_nxt = 1'b1;
              end
              stime_nxt = time_r;
            end
          end
          CMD_CANCEL: begin
            pgen_nxt = '0;
            pnow_nxt = 1'b0;
          end
          CMD_CLEAR: begin
            latest_nxt = '0;
            pgen_nxt   = '0;
            rgen_nxt   = '0;
            sgen_nxt   = '0;
            stime_nxt  = '0;
            sum_nxt    = '0;
            ivc_nxt    = '0;
            for (int i = 0; i < CNT_NUM; i++) cnt_nxt[i] = '0;
            pnow_nxt   = 1'b0;
            pmax_nxt   = 1'b0;
            maxiv_nxt  = '0;
            avg_nxt    = '0;
            fps_nxt    = '0;
          end
          default: begin
            ivok_nxt = 1'b0;
          end
        endcase
      end

      // Guarded accumulation and maximum
      ST_ACC: begin
        if (ivok_r) begin
          if (!sum_ext[SUM_W] && ivc_r != '1) begin
            sum_nxt = sum_ext[SUM_W-1:0];
            ivc_nxt = ivc_r + 1'b1;
          end
          if (iv_r > maxiv_r) maxiv_nxt = iv_r;
        end
      end

      // Rate dividend and start of the average division
      ST_MUL: begin
        prod_nxt = ivc_r * FPS_SCALE;
        rem_nxt  = '0;
        quo_nxt  = sum_r;
        dsr_nxt  = SUM_W'(ivc_r);
        iter_nxt = '0;
      end

      // Average interval, then load the rate division
      ST_DIV_AVG: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        iter_nxt = iter_r + 1'b1;
        if (div_last) begin
          avg_nxt  = quo_step[GEN_W-1:0];
          // Rate quotient stays below 2^28, so the upper dividend bits start as remainder
          rem_nxt  = SUM_W'(prod_r[PROD_W-1:FPS_W]);
          quo_nxt  = {prod_r[FPS_W-1:0], (SUM_W - FPS_W)'(0)};
          dsr_nxt  = sum_r;
          iter_nxt = '0;
        end
      end

      // Frames per second
      ST_DIV_FPS: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        iter_nxt = iter_r + 1'b1;
        if (div_last) fps_nxt = quo_step[FPS_W-1:0];
      end

      // Snapshot into the output register
      ST_DONE: begin
        if (out_load) begin
          oval_nxt  = 1'b1;
          odata_nxt = {2'b00, fps_r, avg_r, GEN_W'(maxiv_r), pmax_r, pnow_r,
                       cnt_ext[CNT_SWAPPED][OUT_CNT_W-1:0],
                       cnt_ext[CNT_DUPLICATE][OUT_CNT_W-1:0],
                       cnt_ext[CNT_RENDERED][OUT_CNT_W-1:0],
                       cnt_ext[CNT_COALESCED][OUT_CNT_W-1:0],
                       cnt_ext[CNT_RECEIVED][OUT_CNT_W-1:0]};
        end
      end

      default: begin
        iter_nxt = '0;
      end
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      oval_r   <= 1'b0;
      latest_r <= '0;
      pgen_r   <= '0;
      rgen_r   <= '0;
      sgen_r   <= '0;
      stime_r  <= '0;
      sum_r    <= '0;
      ivc_r    <= '0;
      for (int i = 0; i < CNT_NUM; i++) cnt_r[i] <= '0;
      pnow_r   <= 1'b0;
      pmax_r   <= 1'b0;
      maxiv_r  <= '0;
      avg_r    <= '0;
      fps_r    <= '0;
      ivok_r   <= 1'b0;
      iter_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      oval_r   <= oval_nxt;
      latest_r <= latest_nxt;
      pgen_r   <= pgen_nxt;
      rgen_r   <= rgen_nxt;
      sgen_r   <= sgen_nxt;
      stime_r  <= stime_nxt;
      sum_r    <= sum_nxt;
      ivc_r    <= ivc_nxt;
      for (int i = 0; i < CNT_NUM; i++) cnt_r[i] <= cnt_nxt[i];
      pnow_r   <= pnow_nxt;
      pmax_r   <= pmax_nxt;
      maxiv_r  <= maxiv_nxt;
      avg_r    <= avg_nxt;
      fps_r    <= fps_nxt;
      ivok_r   <= ivok_nxt;
      iter_r   <= iter_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    gen_r   <= gen_nxt;
    time_r  <= time_nxt;
    iv_r    <= iv_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dsr_r   <= dsr_nxt;
    odata_r <= odata_nxt;
  end

endmodule
